@@ src/wsfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_pkg
// Opcodes, length codes and small helpers shared by the websocket frame
// decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OPCODE_W = 4;
	localparam int unsigned LEN_W    = 64;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned LCODE_W  = 7;
	localparam int unsigned USER_W   = 8;

	localparam logic [OPCODE_W-1:0] OPC_CONT  = 4'h0;
	localparam logic [OPCODE_W-1:0] OPC_TEXT  = 4'h1;
	localparam logic [OPCODE_W-1:0] OPC_BIN   = 4'h2;
	localparam logic [OPCODE_W-1:0] OPC_CLOSE = 4'h8;
	localparam logic [OPCODE_W-1:0] OPC_PING  = 4'h9;
	localparam logic [OPCODE_W-1:0] OPC_PONG  = 4'hA;

	localparam logic [LCODE_W-1:0] LCODE_EXT16 = 7'd126;
	localparam logic [LCODE_W-1:0] LCODE_EXT64 = 7'd127;

	// Index of the last extended-length or key byte, counted from zero.
	localparam logic [2:0] EXT16_LAST = 3'd1;
	localparam logic [2:0] EXT64_LAST = 3'd7;
	localparam logic [2:0] KEY_LAST   = 3'd3;

	function automatic logic is_data_op(input logic [OPCODE_W-1:0] op);
		return (op == OPC_CONT) || (op == OPC_TEXT) || (op == OPC_BIN);
	endfunction

	function automatic logic is_known_op(input logic [OPCODE_W-1:0] op);
		return is_data_op(op) || (op == OPC_CLOSE) || (op == OPC_PING) ||
			(op == OPC_PONG);
	endfunction

endpackage

@@ src/websocket_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Parses received websocket frames byte by byte and streams out unmasked
// payload bytes of data frames, with end-of-message and bad-opcode marks.
// ----------------------------------------------------------------------------
// The decoder takes one received byte per clock cycle while the output is not
// held back by m_tready: each byte is captured in an input register and
// parsed by a single pass of header, length and unmasking logic into an
// output register. A byte is taken while a previous result still waits at
// the output as long as the output register is free or being drained in the
// same cycle. Header bytes produce no result, except a bad-opcode mark for an
// unknown opcode or an end mark for an empty final data frame at the last
// header byte; payload bytes of close, ping, pong and unknown frames produce
// none. The s_tlast chunk marker is accepted with each byte but unused.
module websocket_frame_decoder
	import wsfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
	input  logic              s_tlast,   // chunk_last
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // [7:0] payload_byte
	output logic [USER_W-1:0] m_tuser,   // [0] has_byte, [4:1] frame_opcode,
	                                     // [5] bad_opcode, [7:6] zero
	output logic              m_tlast    // message_end
);

	typedef enum logic [2:0] {
		PH_B0   = 3'd0,
		PH_B1   = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Parser state
	phase_t              phase_q;
	logic [2:0]          hdr_cnt_q;
	logic                fin_q;
	logic [OPCODE_W-1:0] opcode_q;
	logic                mask_q;
	logic [LCODE_W-1:0]  lcode_q;
	logic [LEN_W-1:0]    remain_q;
	logic [KEY_W-1:0]    key_q;
	logic [1:0]          key_idx_q;

	// Output stage
	logic                valid_s2;
	logic [BYTE_W-1:0]   byte_s2;
	logic                has_s2;
	logic [OPCODE_W-1:0] opcode_s2;
	logic                end_s2;
	logic                bad_s2;

	logic advance;

	// Next-state and result of the byte in the input stage
	phase_t              phase_d;
	logic [2:0]          hdr_cnt_d;
	logic                fin_d;
	logic [OPCODE_W-1:0] opcode_d;
	logic                mask_d;
	logic [LCODE_W-1:0]  lcode_d;
	logic [LEN_W-1:0]    remain_d;
	logic [KEY_W-1:0]    key_d;
	logic [1:0]          key_idx_d;
	logic                res_valid;
	logic [BYTE_W-1:0]   res_byte;
	logic                res_has;
	logic                res_end;
	logic                res_bad;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		logic             hdr_done;
		logic [LEN_W-1:0] ext_len;
		logic [LEN_W-1:0] dec_len;
		logic [2:0]       ext_last;
		logic [BYTE_W-1:0] key_byte;

		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		lcode_d   = lcode_q;
		remain_d  = remain_q;
		key_d     = key_q;
		key_idx_d = key_idx_q;
		res_valid = 1'b0;
		res_byte  = '0;
		res_has   = 1'b0;
		res_end   = 1'b0;
		res_bad   = 1'b0;
		hdr_done  = 1'b0;
		ext_len   = {remain_q[LEN_W-BYTE_W-1:0], byte_s1};
		dec_len   = remain_q - {{(LEN_W-1){1'b0}}, (remain_q != '0)};
		ext_last  = (lcode_q == LCODE_EXT16) ? EXT16_LAST : EXT64_LAST;
		key_byte  = '0;

		case (phase_q)
			PH_B1: begin
				mask_d    = byte_s1[7];
				lcode_d   = byte_s1[LCODE_W-1:0];
				key_d     = '0;
				hdr_cnt_d = '0;
				if (byte_s1[LCODE_W-1:0] == LCODE_EXT16 ||
					byte_s1[LCODE_W-1:0] == LCODE_EXT64) begin
					remain_d = '0;
					phase_d  = PH_EXT;
				end else begin
					remain_d = {{(LEN_W-LCODE_W){1'b0}}, byte_s1[LCODE_W-1:0]};
					if (byte_s1[7]) begin
						phase_d = PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_EXT: begin
				remain_d  = ext_len;
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == ext_last) begin
					hdr_cnt_d = '0;
					if (mask_q) begin
						phase_d = PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_KEY: begin
				key_d     = {key_q[KEY_W-BYTE_W-1:0], byte_s1};
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == KEY_LAST) begin
					hdr_done = 1'b1;
				end
			end
			PH_DATA: begin
				if (mask_q) begin
					case (key_idx_q)
						2'd0:    key_byte = key_q[31:24];
						2'd1:    key_byte = key_q[23:16];
						2'd2:    key_byte = key_q[15:8];
						default: key_byte = key_q[7:0];
					endcase
				end
				key_idx_d = key_idx_q + 2'd1;
				remain_d  = dec_len;
				if (dec_len == '0) begin
					phase_d = PH_B0;
				end
				if (is_data_op(opcode_q)) begin
					res_valid = 1'b1;
					res_byte  = byte_s1 ^ key_byte;
					res_has   = 1'b1;
					res_end   = fin_q && (dec_len == '0);
				end
			end
			default: begin
				fin_d    = byte_s1[7];
				opcode_d = byte_s1[OPCODE_W-1:0];
				phase_d  = PH_B1;
			end
		endcase

		// End of header: remain_d already holds the full payload length.
		if (hdr_done) begin
			key_idx_d = '0;
			hdr_cnt_d = '0;
			phase_d   = (remain_d == '0) ? PH_B0 : PH_DATA;
			if (!is_known_op(opcode_q)) begin
				res_valid = 1'b1;
				res_bad   = 1'b1;
			end else if (is_data_op(opcode_q) && remain_d == '0 && fin_q) begin
				res_valid = 1'b1;
				res_end   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			phase_q   <= PH_B0;
			hdr_cnt_q <= '0;
			fin_q     <= 1'b0;
			opcode_q  <= '0;
			mask_q    <= 1'b0;
			lcode_q   <= '0;
			remain_q  <= '0;
			key_q     <= '0;
			key_idx_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				phase_q   <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				fin_q     <= fin_d;
				opcode_q  <= opcode_d;
				mask_q    <= mask_d;
				lcode_q   <= lcode_d;
				remain_q  <= remain_d;
				key_q     <= key_d;
				key_idx_q <= key_idx_d;
				valid_s2  <= res_valid;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			byte_s2   <= res_byte;
			has_s2    <= res_has;
			opcode_s2 <= opcode_q;
			end_s2    <= res_end;
			bad_s2    <= res_bad;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = byte_s2;
	assign m_tuser  = {2'b00, bad_s2, opcode_s2, has_s2};
	assign m_tlast  = end_s2;

`ifndef ASSERT_OFF
	// A payload phase always has bytes left to take.
	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remain_q != '0))
		else $error("payload phase entered with zero bytes remaining");

	// An error result carries neither a byte nor an end mark.
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && bad_s2) |-> (!has_s2 && !end_s2))
		else $error("bad opcode result carries data or end mark");

	// Payload bytes are only delivered for data frames.
	a_byte_data_op: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && has_s2) |-> is_data_op(opcode_s2))
		else $error("payload byte delivered for a non-data opcode");

	// The key byte counter stays within the four masking key bytes.
	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY) |-> (hdr_cnt_q <= KEY_LAST))
		else $error("masking key counter out of range");
`endif

endmodule

@@ test/tb_websocket_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_decoder
// Feeds byte streams of websocket frames into the decoder and checks every
// output against a cycle-independent frame parser. The streams hold short,
// 16-bit and 64-bit lengths, masked and unmasked frames, and data, control
// and unknown opcodes. Both stream sides idle at random, and the run also
// includes one long output stall and several full drains.
// ----------------------------------------------------------------------------
module tb_websocket_frame_decoder;
	import wsfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_STALL     = 300;
	localparam int DRAIN_TAIL     = 8;
	localparam int MAX_PRINTED    = 30;

	typedef enum logic [2:0] {
		P_FIRST,
		P_SECOND,
		P_XLEN,
		P_KEY,
		P_BODY
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic [3:0] opc;
		logic       eom;
		logic       bad;
	} ws_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [BYTE_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;
	logic              m_tlast;

	websocket_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rx_item_t   rx_stream[$];
	ws_result_t pending_results[$];

	// Control flags, written only at falling edges.
	logic calm = 1'b0;
	logic stall_req = 1'b0;

	int errors = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int ends_seen = 0;
	int bads_seen = 0;
	int frames_built = 0;

	// Parser state of the expected behavior.
	parse_phase_t ph = P_FIRST;
	logic [3:0]   hdr_cnt = '0;
	logic         fin_bit = 1'b0;
	logic [3:0]   op = '0;
	logic         masked = 1'b0;
	logic [6:0]   lcode = '0;
	logic [63:0]  remain = '0;
	logic [31:0]  key = '0;
	logic [1:0]   key_idx = '0;

	function automatic logic op_is_data(input logic [3:0] o);
		return o == OPC_CONT || o == OPC_TEXT || o == OPC_BIN;
	endfunction

	function automatic logic op_is_known(input logic [3:0] o);
		return op_is_data(o) || o == OPC_CLOSE || o == OPC_PING || o == OPC_PONG;
	endfunction

	task automatic expect_result(input logic [7:0] d, input logic has, input logic eom,
			input logic bad);
		ws_result_t r;
		r.data = d;
		r.has  = has;
		r.opc  = op;
		r.eom  = eom;
		r.bad  = bad;
		pending_results.push_back(r);
	endtask

	task automatic header_end();
		key_idx = '0;
		hdr_cnt = '0;
		ph = (remain == 64'd0) ? P_FIRST : P_BODY;
		if (!op_is_known(op))
			expect_result(8'h00, 1'b0, 1'b0, 1'b1);
		else if (op_is_data(op) && remain == 64'd0 && fin_bit)
			expect_result(8'h00, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		logic [7:0] k;
		logic [3:0] need;
		case (ph)
			P_SECOND: begin
				masked  = b[7];
				lcode   = b[6:0];
				key     = '0;
				hdr_cnt = '0;
				if (lcode == LCODE_EXT16 || lcode == LCODE_EXT64) begin
					remain = '0;
					ph = P_XLEN;
				end else begin
					remain = {57'd0, lcode};
					if (masked)
						ph = P_KEY;
					else
						header_end();
				end
			end
			P_XLEN: begin
				remain  = {remain[55:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				need    = (lcode == LCODE_EXT16) ? 4'd2 : 4'd8;
				if (hdr_cnt >= need) begin
					hdr_cnt = '0;
					if (masked)
						ph = P_KEY;
					else
						header_end();
				end
			end
			P_KEY: begin
				key     = {key[23:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= 4'd4)
					header_end();
			end
			P_BODY: begin
				// Key bytes are used most significant first.
				k = masked ? key[8 * (3 - key_idx) +: 8] : 8'h00;
				key_idx = key_idx + 2'd1;
				if (remain != 64'd0)
					remain = remain - 64'd1;
				if (remain == 64'd0)
					ph = P_FIRST;
				if (op_is_data(op))
					expect_result(b ^ k, 1'b1, fin_bit && remain == 64'd0, 1'b0);
			end
			default: begin
				fin_bit = b[7];
				op      = b[3:0];
				ph      = P_SECOND;
			end
		endcase
	endtask

	task automatic report(input string msg);
		if (errors < MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Driver: offers the next byte once the previous request is taken.
	rx_item_t drv_item;
	int       src_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				s_tvalid <= 1'b0;
				src_gap  <= src_gap - 1;
			end else if (rx_stream.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				s_tvalid <= 1'b0;
				src_gap  <= $urandom_range(0, 17);
			end else begin
				drv_item = rx_stream.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= drv_item.data;
				s_tlast  <= drv_item.last;
			end
		end
	end

	// Receiver readiness, with random gaps and one long hold-off.
	int rdy_gap = 0;
	int stall_cnt = 0;
	logic stall_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_cnt != 0) begin
			m_tready  <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else if (stall_req && !stall_done) begin
			m_tready   <= 1'b0;
			stall_cnt  <= LONG_STALL;
			stall_done <= 1'b1;
		end else if (rdy_gap != 0) begin
			m_tready <= 1'b0;
			rdy_gap  <= rdy_gap - 1;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			m_tready <= 1'b0;
			rdy_gap  <= $urandom_range(0, 17);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Checker first, then prediction, so one edge is handled in a fixed order.
	ws_result_t got;
	ws_result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.data = m_tdata;
				got.has  = m_tuser[0];
				got.opc  = m_tuser[4:1];
				got.bad  = m_tuser[5];
				got.eom  = m_tlast;
				results_seen++;
				if (got.eom)
					ends_seen++;
				if (got.bad)
					bads_seen++;
				if (pending_results.size() == 0) begin
					report($sformatf("unexpected result data=%02h user=%02h last=%0b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want = pending_results.pop_front();
					if (got.data !== want.data)
						report($sformatf("payload_byte %02h, want %02h", got.data, want.data));
					if (got.has !== want.has)
						report($sformatf("has_byte %0b, want %0b", got.has, want.has));
					if (got.opc !== want.opc)
						report($sformatf("frame_opcode %0h, want %0h", got.opc, want.opc));
					if (got.eom !== want.eom)
						report($sformatf("message_end %0b, want %0b", got.eom, want.eom));
					if (got.bad !== want.bad)
						report($sformatf("bad_opcode %0b, want %0b", got.bad, want.bad));
					if (m_tuser[7:6] !== 2'b00)
						report($sformatf("spare tuser bits %02b", m_tuser[7:6]));
				end
			end
			if (s_tvalid && s_tready) begin
				parse_rx_byte(s_tdata);
				bytes_taken++;
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_websocket_frame_decoder NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		rx_item_t it;
		it.data = b;
		it.last = 1'($urandom_range(0, 1));
		rx_stream.push_back(it);
	endtask

	// lmode: 0 short length, 1 16-bit extended, 2 64-bit extended.
	task automatic add_frame(input logic fin, input logic [3:0] opc, input logic mask,
			input int lmode, input logic [63:0] len, input int nsend,
			input logic [31:0] mkey);
		logic [2:0] rsv;
		logic [6:0] code;
		rsv = 3'($urandom_range(0, 7));
		code = (lmode == 1) ? LCODE_EXT16 : (lmode == 2) ? LCODE_EXT64 : len[6:0];
		queue_byte({fin, rsv, opc});
		queue_byte({mask, code});
		if (lmode == 1) begin
			queue_byte(len[15:8]);
			queue_byte(len[7:0]);
		end else if (lmode == 2) begin
			for (int i = 7; i >= 0; i--)
				queue_byte(len[8 * i +: 8]);
		end
		if (mask) begin
			for (int i = 3; i >= 0; i--)
				queue_byte(mkey[8 * i +: 8]);
		end
		for (int i = 0; i < nsend; i++)
			queue_byte(8'($urandom_range(0, 255)));
		frames_built++;
	endtask

	task automatic add_random_frame();
		int         pick;
		int         lmode;
		logic [3:0] opc;
		logic [63:0] len;
		logic [31:0] mkey;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			case ($urandom_range(0, 2))
				0: opc = OPC_CONT;
				1: opc = OPC_TEXT;
				default: opc = OPC_BIN;
			endcase
		end else if (pick < 78) begin
			case ($urandom_range(0, 2))
				0: opc = OPC_CLOSE;
				1: opc = OPC_PING;
				default: opc = OPC_PONG;
			endcase
		end else begin
			do
				opc = 4'($urandom_range(0, 15));
			while (op_is_known(opc));
		end
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			lmode = 0;
			len = 64'($urandom_range(0, 16));
		end else if (pick < 80) begin
			lmode = 0;
			len = 64'($urandom_range(0, 125));
		end else if (pick < 92) begin
			lmode = 1;
			len = 64'($urandom_range(0, 300));
		end else begin
			lmode = 2;
			len = 64'($urandom_range(0, 40));
		end
		pick = $urandom_range(0, 9);
		mkey = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		add_frame($urandom_range(0, 3) != 0, opc, 1'($urandom_range(0, 1)), lmode, len,
			int'(len), mkey);
	endtask

	// Waits until the stream is sent and every result is back, then idles for the given tail.
	task automatic drain(input int tail);
		while (rx_stream.size() != 0 || s_tvalid)
			@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames.
		add_frame(1'b1, OPC_TEXT, 1'b0, 0, 64'd0, 0, 32'h0);       // empty FIN data
		add_frame(1'b0, OPC_BIN, 1'b0, 0, 64'd0, 0, 32'h0);        // empty non-FIN data
		add_frame(1'b1, OPC_PING, 1'b0, 0, 64'd0, 0, 32'h0);       // empty control
		add_frame(1'b1, 4'h3, 1'b0, 0, 64'd0, 0, 32'h0);           // unknown, no payload
		add_frame(1'b1, OPC_TEXT, 1'b1, 0, 64'd2, 2, 32'hFFFF_FFFF);
		add_frame(1'b1, OPC_CLOSE, 1'b0, 0, 64'd1, 1, 32'h0);
		add_frame(1'b0, 4'hF, 1'b0, 0, 64'd1, 1, 32'h0);           // unknown, skipped byte
		add_frame(1'b1, OPC_CONT, 1'b0, 1, 64'd0, 0, 32'h0);       // empty via 16-bit length
		drain(DRAIN_TAIL);

		// First random batch, with a long output stall while bytes keep coming.
		while (rx_stream.size() < 600)
			add_random_frame();
		while (rx_stream.size() > 350)
			@(negedge clk);
		stall_req = 1'b1;
		drain(DRAIN_TAIL);

		// Second random batch, ending with a huge 64-bit length left unfinished.
		while (rx_stream.size() < 600)
			add_random_frame();
		add_frame(1'b1, OPC_BIN, 1'b1, 2, 64'hFF00_0000_0000_0123, 40, $urandom);
		while (rx_stream.size() > 150)
			@(negedge clk);
		calm = 1'b1;
		drain(DRAIN_TAIL + 2);

		$display("run covered %0d frames, %0d bytes in, %0d results out",
			frames_built, bytes_taken, results_seen);
		$display("results held %0d message ends and %0d bad opcode marks; %0d mismatches",
			ends_seen, bads_seen, errors);
		if (errors == 0)
			$display("tb_websocket_frame_decoder OK");
		else
			$display("tb_websocket_frame_decoder NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
src/wsfd_pkg.sv
src/websocket_frame_decoder.sv
test/tb_websocket_frame_decoder.sv
